// ===== src/mbrtu_pkg.sv =====
// Shared types, codes and the CRC-16/MODBUS byte step for the Modbus RTU
// slave frame dispatch block. No dependencies.
package mbrtu_pkg;

  localparam int RX_BUF_SIZE_DEF = 256;
  localparam int NUM_RESP_DEF    = 4;

  localparam int          CFG_IDX_W      = 3;
  localparam int          SLOT_W         = 41;
  localparam int          RESP_W         = 2;
  localparam int          HDR_LEN        = 6;
  localparam int          MIN_FRAME      = 4;
  localparam int          TX_LEN         = 5;
  localparam logic [7:0]  EXC_FLAG       = 8'h80;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FUNC_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXC_CODE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT0      = 3'd3;

  localparam logic [7:0] OWN_ADDR_RST   = 8'd1;
  localparam logic [7:0] FUNC_LIMIT_RST = 8'd16;
  localparam logic [7:0] EXC_CODE_RST   = 8'd2;

  // Input command and output word kind
  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_GAP     = 1'b1;
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_TX     = 1'b1;

  typedef enum logic [2:0] {
    ST_SHORT      = 3'd0,
    ST_CRC_BAD    = 3'd1,
    ST_NOT_OURS   = 3'd2,
    ST_DISPATCHED = 3'd3,
    ST_NO_RESP    = 3'd4
  } status_t;

  typedef struct packed {
    logic        vld;
    logic [7:0]  func;
    logic [15:0] reg_start;
    logic [15:0] reg_end;
  } slot_t;

  typedef struct packed {
    logic [7:0] own_addr;
    logic [7:0] func_limit;
    logic [7:0] exc_code;
  } cfg_t;

  // Frame-end event handed from the frame checker to the output queue
  typedef struct packed {
    logic              valid;
    status_t           status;
    logic [RESP_W-1:0] responder;
    logic [7:0]        func;
  } load_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== src/mbrtu_cfg.sv =====
// Configuration register file: address, function limit, exception code and
// responder slots. Depends on mbrtu_pkg.
module mbrtu_cfg import mbrtu_pkg::*; #(
  parameter int NUM_RESPONDERS = NUM_RESP_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SLOT_W-1:0]    cfg_data,
  output cfg_t                 cfg,
  output slot_t                slots [NUM_RESPONDERS]
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_addr   <= OWN_ADDR_RST;
      cfg.func_limit <= FUNC_LIMIT_RST;
      cfg.exc_code   <= EXC_CODE_RST;
      for (int i = 0; i < NUM_RESPONDERS; i++) begin
        slots[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_OWN_ADDR:   cfg.own_addr   <= cfg_data[7:0];
        CFG_FUNC_LIMIT: cfg.func_limit <= cfg_data[7:0];
        CFG_EXC_CODE:   cfg.exc_code   <= cfg_data[7:0];
        default: ;
      endcase
      for (int i = 0; i < NUM_RESPONDERS; i++) begin
        if (cfg_index == CFG_SLOT0 + CFG_IDX_W'(i)) begin
          slots[i] <= slot_t'(cfg_data);
        end
      end
    end
  end

endmodule

// ===== src/mbrtu_frame.sv =====
// Input register, frame state (count, CRC, delay line, header) and the
// frame-end status decision. Depends on mbrtu_pkg.
module mbrtu_frame import mbrtu_pkg::*; #(
  parameter int RX_BUF_SIZE    = RX_BUF_SIZE_DEF,
  parameter int NUM_RESPONDERS = NUM_RESP_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       cmd,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  input  slot_t      slots [NUM_RESPONDERS],
  input  logic       q_free,
  output load_t      load
);

  localparam int CNT_W = $clog2(RX_BUF_SIZE + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RX_BUF_SIZE);

  // input register
  logic       s_valid;
  logic       s_cmd;
  logic [7:0] s_byte;

  // frame state
  logic [CNT_W-1:0] byte_count;
  logic [15:0]      running_crc;
  logic [7:0]       dly [2];
  logic [7:0]       hdr [HDR_LEN];

  // state as it stands once the registered word is applied
  logic [CNT_W-1:0] e_count;
  logic [15:0]      e_crc;
  logic [7:0]       e_dly [2];
  logic [7:0]       e_hdr [HDR_LEN];

  logic        fin;
  logic        adv;
  logic [15:0] reg_addr;
  logic [15:0] reg_qty;
  logic [16:0] reg_sum;
  logic        hit;
  logic [RESP_W-1:0] hit_idx;
  status_t     st;

  always_comb begin
    e_count  = byte_count;
    e_crc    = running_crc;
    e_dly[0] = dly[0];
    e_dly[1] = dly[1];
    for (int h = 0; h < HDR_LEN; h++) begin
      e_hdr[h] = hdr[h];
    end
    if (s_cmd == CMD_BYTE) begin
      e_count  = byte_count + 1'b1;
      // the two newest bytes are held back; they are the received CRC
      if (byte_count >= CNT_W'(2)) begin
        e_crc = crc_update(running_crc, dly[0]);
      end
      e_dly[0] = dly[1];
      e_dly[1] = s_byte;
      for (int h = 0; h < HDR_LEN; h++) begin
        if (byte_count == CNT_W'(h)) begin
          e_hdr[h] = s_byte;
        end
      end
    end
  end

  assign fin      = (s_cmd == CMD_GAP) || (e_count >= CNT_FULL);
  assign adv      = s_valid && (!fin || q_free);
  assign in_stall = s_valid && !adv;

  assign reg_addr = {e_hdr[2], e_hdr[3]};
  assign reg_qty  = {e_hdr[4], e_hdr[5]};
  assign reg_sum  = {1'b0, reg_addr} + {1'b0, reg_qty};

  // first valid slot with matching function (and register window) wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = NUM_RESPONDERS - 1; i >= 0; i--) begin
      if (slots[i].vld && slots[i].func == e_hdr[1] &&
          (e_hdr[1] > cfg.func_limit ||
           (reg_addr >= slots[i].reg_start && reg_sum < {1'b0, slots[i].reg_end}))) begin
        hit     = 1'b1;
        hit_idx = RESP_W'(i);
      end
    end
  end

  always_comb begin
    if (e_count < CNT_W'(MIN_FRAME)) begin
      st = ST_SHORT;
    end else if (e_crc != {e_dly[1], e_dly[0]}) begin
      st = ST_CRC_BAD;
    end else if (e_hdr[0] != cfg.own_addr) begin
      st = ST_NOT_OURS;
    end else if (hit) begin
      st = ST_DISPATCHED;
    end else begin
      st = ST_NO_RESP;
    end
  end

  always_comb begin
    load.valid     = adv && fin;
    load.status    = st;
    load.responder = (st == ST_DISPATCHED) ? hit_idx : '0;
    load.func      = e_hdr[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s_valid <= 1'b1;
    end else if (adv) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s_cmd  <= cmd;
      s_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (adv && fin)) begin
      byte_count  <= '0;
      running_crc <= CRC_INIT;
      dly[0]      <= '0;
      dly[1]      <= '0;
      for (int h = 0; h < HDR_LEN; h++) begin
        hdr[h] <= '0;
      end
    end else if (adv) begin
      byte_count  <= e_count;
      running_crc <= e_crc;
      dly[0]      <= e_dly[0];
      dly[1]      <= e_dly[1];
      for (int h = 0; h < HDR_LEN; h++) begin
        hdr[h] <= e_hdr[h];
      end
    end
  end

endmodule

// ===== src/mbrtu_txq.sv =====
// Result register: holds one frame-end event and plays out the status word
// and, for an unmatched frame, the five exception bytes. Depends on mbrtu_pkg.
module mbrtu_txq import mbrtu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  load_t             load,
  input  cfg_t              cfg,
  output logic              q_free,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              kind,
  output logic [2:0]        status,
  output logic [RESP_W-1:0] responder,
  output logic [7:0]        tx_byte,
  output logic              last
);

  localparam logic [2:0] IDX_LAST = 3'(TX_LEN);

  logic              q_valid;
  logic [2:0]        idx;
  status_t           q_status;
  logic [RESP_W-1:0] q_resp;
  logic [7:0]        tx0;
  logic [7:0]        tx1;
  logic [7:0]        tx2;
  logic [15:0]       tx_crc;
  logic [7:0]        ld_func;
  logic [15:0]       ld_crc;

  assign ld_func = load.func | EXC_FLAG;
  assign ld_crc  = crc_update(crc_update(crc_update(CRC_INIT, cfg.own_addr), ld_func),
                              cfg.exc_code);

  assign q_free    = !q_valid;
  assign out_valid = q_valid;

  always_comb begin
    last      = (idx == '0) ? (q_status != ST_NO_RESP) : (idx == IDX_LAST);
    kind      = (idx == '0) ? KIND_STATUS : KIND_TX;
    status    = (idx == '0) ? q_status : ST_NO_RESP;
    responder = (idx == '0) ? q_resp : '0;
    case (idx)
      3'd1:    tx_byte = tx0;
      3'd2:    tx_byte = tx1;
      3'd3:    tx_byte = tx2;
      3'd4:    tx_byte = tx_crc[7:0];
      3'd5:    tx_byte = tx_crc[15:8];
      default: tx_byte = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
      idx     <= '0;
    end else if (load.valid) begin
      q_valid <= 1'b1;
      idx     <= '0;
    end else if (q_valid && !out_stall) begin
      if (last) begin
        q_valid <= 1'b0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load.valid) begin
      q_status <= load.status;
      q_resp   <= load.responder;
      tx0      <= cfg.own_addr;
      tx1      <= ld_func;
      tx2      <= cfg.exc_code;
      tx_crc   <= ld_crc;
    end
  end

endmodule

// ===== src/modbus_rtu_slave_frame_dispatch_core.sv =====
// Modbus RTU slave frame check and dispatch. A frame-ending word passes the input
// register, then the result register, before its status word appears.
// Throughput: one received byte per cycle while no frame end waits for the result
// register. A frame end needs a free result register, which frees the cycle after
// its last word is taken: the status word, or the 1 + 5 words of an exception reply.
// Reset (rst, synchronous, active high) clears the frame state to an empty frame with
// CRC 0xFFFF, empties both registers and loads the configuration defaults.
module modbus_rtu_slave_frame_dispatch_core import mbrtu_pkg::*; #(
  parameter int RX_BUF_SIZE    = RX_BUF_SIZE_DEF,
  parameter int NUM_RESPONDERS = NUM_RESP_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // received words: a byte, or the end-of-gap tick
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 cmd,
  input  logic [7:0]           rx_byte,
  // result words: frame status, then any exception bytes
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 kind,
  output logic [2:0]           status,
  output logic [RESP_W-1:0]    responder,
  output logic [7:0]           tx_byte,
  output logic                 last,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SLOT_W-1:0]    cfg_data
);

  cfg_t  cfg;
  slot_t slots [NUM_RESPONDERS];
  load_t load;
  logic  q_free;

  // Register file; slots past NUM_RESPONDERS are not stored and their
  // writes are dropped.
  mbrtu_cfg #(
    .NUM_RESPONDERS(NUM_RESPONDERS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .slots     (slots)
  );

  // Frame tracker. Every byte updates count, header capture and the CRC
  // (which trails the input by two bytes so the trailing CRC stays out).
  // A gap tick or the byte that fills the buffer ends the frame: status
  // is decided from the updated state in the same cycle and the frame
  // state returns to empty. A frame end waits while the result register
  // is still busy; a byte waits only behind such a held frame end.
  mbrtu_frame #(
    .RX_BUF_SIZE    (RX_BUF_SIZE),
    .NUM_RESPONDERS (NUM_RESPONDERS)
  ) u_frame (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .rx_byte  (rx_byte),
    .cfg      (cfg),
    .slots    (slots),
    .q_free   (q_free),
    .load     (load)
  );

  // Result register: status word first; for an unmatched frame the
  // exception reply (address, function|0x80, code, CRC lo, CRC hi) follows.
  mbrtu_txq u_txq (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .cfg       (cfg),
    .q_free    (q_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .status    (status),
    .responder (responder),
    .tx_byte   (tx_byte),
    .last      (last)
  );

endmodule

// ===== src/mbrtu_checker.sv =====
// Port-level checks for the frame dispatch core, bound to the top level.
// Depends on mbrtu_pkg and modbus_rtu_slave_frame_dispatch_core.
module mbrtu_checker import mbrtu_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 kind,
  input logic [2:0]           status,
  input logic [RESP_W-1:0]    responder,
  input logic [7:0]           tx_byte,
  input logic                 last
);

  // exception bytes only belong to an unmatched frame
  a_tx_is_noresp: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_TX |-> status == ST_NO_RESP && responder == '0)
    else $error("tx word without no-responder status");

  // only an unmatched frame continues past its status word
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_STATUS |-> (last == (status != ST_NO_RESP)))
    else $error("status word last flag wrong");

  // a word that is not last is followed at once by a tx word
  a_burst_cont: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> out_valid && kind == KIND_TX)
    else $error("exception reply broken off");

  // held result word keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid &&
      $stable({kind, status, responder, tx_byte, last}))
    else $error("stalled result word changed");

endmodule

bind modbus_rtu_slave_frame_dispatch_core mbrtu_checker u_mbrtu_checker (.*);
